FILE: design/aarm_pkg.sv
// shared types, constants and the arctangent table for the rotation matrix block
`default_nettype none

package aarm_pkg;

  // cordic datapath width: Q30 with headroom for the growing vector
  localparam int CW = 34;
  // width for the unfolded angle, |angle| up to 8 rad in Q30
  localparam int RW = 36;
  // width of rounded cos and sin in Q1.14
  localparam int SW = 18;
  // width of one entry sum in Q42
  localparam int EW = 54;
  // hard limit of the arctangent table
  localparam int TABLE_LEN = 32;

  localparam logic signed [RW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [RW-1:0] Q30_NEG_PI  = -36'sd3373259426;
  localparam logic signed [RW-1:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [RW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [RW-1:0] Q30_NEG_HALF_PI = -36'sd1686629713;
  localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic               flip;
  } side_t;

  // truncated atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/axis_angle_rotation_matrix.sv
// axis-angle to 3x3 rotation matrix: angle reduction, cordic chain and matrix pipeline
//
//  channel | direction | signals                               | transfer when
//  --------+-----------+---------------------------------------+----------------------
//  in      | input     | axis_x axis_y axis_z angle            | in_valid & in_ready
//  out     | output    | r00 r01 r02 r10 r11 r12 r20 r21 r22   | out_valid & out_ready
//
// one transfer a cycle in each direction while out_ready stays high; the stages are
// reduce, fold, one cell per cordic iteration, round, three matrix stages, output
// every stage holds its own valid bit, so the pipe fills while the output stalls
// and a bubble in any stage is filled by the stage behind it
// reset clears only the valid bits; the data registers are not reset
`default_nettype none

module axis_angle_rotation_matrix #(
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] axis_x,
  input  wire logic [15:0] axis_y,
  input  wire logic [15:0] axis_z,
  input  wire logic [15:0] angle,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      r00,
  output logic [15:0]      r01,
  output logic [15:0]      r02,
  output logic [15:0]      r10,
  output logic [15:0]      r11,
  output logic [15:0]      r12,
  output logic [15:0]      r20,
  output logic [15:0]      r21,
  output logic [15:0]      r22
);

  localparam int NSTEP = (CORDIC_STEPS > aarm_pkg::TABLE_LEN) ?
                         aarm_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam int W  = aarm_pkg::CW;
  localparam int RW = aarm_pkg::RW;
  localparam int SW = aarm_pkg::SW;
  localparam int EW = aarm_pkg::EW;
  localparam int TW = SW + 1;
  localparam int PW = 32;
  localparam int QW = PW + TW;
  localparam int NW = 16 + SW;
  localparam int VW = EW - 28;
  localparam logic signed [EW-1:0] RND = EW'(134217728);
  localparam logic signed [VW-1:0] ONE_V = VW'(16384);
  localparam logic signed [VW-1:0] NEG_ONE_V = -VW'(16384);

  // ---------------------------------------------------------------
  // stage a: widen angle to Q30 and bring it into -pi..pi
  // ---------------------------------------------------------------
  logic                 a_v, rdy_a, rdy_b;
  logic signed [RW-1:0] a_z;
  aarm_pkg::side_t      a_side;
  logic signed [RW-1:0] z_raw, z_red;

  assign z_raw = $signed({{(RW-34){angle[15]}}, angle, 18'd0});

  always_comb begin
    if (z_raw > aarm_pkg::Q30_PI) begin
      z_red = z_raw - aarm_pkg::Q30_TWO_PI;
    end else if (z_raw < aarm_pkg::Q30_NEG_PI) begin
      z_red = z_raw + aarm_pkg::Q30_TWO_PI;
    end else begin
      z_red = z_raw;
    end
  end

  assign rdy_a = !a_v || rdy_b;
  assign in_ready = rdy_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (rdy_a) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_z <= z_red;
      a_side.axis_x <= axis_x;
      a_side.axis_y <= axis_y;
      a_side.axis_z <= axis_z;
      a_side.flip <= 1'b0;
    end
  end

  // ---------------------------------------------------------------
  // stage b: fold into -pi/2..pi/2, remember to negate the cosine
  // ---------------------------------------------------------------
  logic                 b_v;
  aarm_pkg::cordic_t    b_data;
  aarm_pkg::side_t      b_side;
  logic signed [RW-1:0] z_fold;
  logic                 flip;

  always_comb begin
    if (a_z > aarm_pkg::Q30_HALF_PI) begin
      z_fold = aarm_pkg::Q30_PI - a_z;
      flip = 1'b1;
    end else if (a_z < aarm_pkg::Q30_NEG_HALF_PI) begin
      z_fold = aarm_pkg::Q30_NEG_PI - a_z;
      flip = 1'b1;
    end else begin
      z_fold = a_z;
      flip = 1'b0;
    end
  end

  logic cr [NSTEP+1];
  logic cv [NSTEP+1];
  aarm_pkg::cordic_t cd [NSTEP+1];
  aarm_pkg::side_t   cs [NSTEP+1];

  assign rdy_b = !b_v || cr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (rdy_b) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && a_v) begin
      b_data.x <= aarm_pkg::Q30_GAIN;
      b_data.y <= '0;
      b_data.z <= z_fold[W-1:0];
      b_side.axis_x <= a_side.axis_x;
      b_side.axis_y <= a_side.axis_y;
      b_side.axis_z <= a_side.axis_z;
      b_side.flip <= flip;
    end
  end

  // ---------------------------------------------------------------
  // cordic chain: one cell per iteration
  // ---------------------------------------------------------------
  assign cv[0] = b_v;
  assign cd[0] = b_data;
  assign cs[0] = b_side;

  for (genvar k = 0; k < NSTEP; k++) begin : g_cell
    aarm_cordic_cell #(
      .STEP(k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(cv[k]),
      .up_ready(cr[k]),
      .up_data (cd[k]),
      .up_side (cs[k]),
      .dn_valid(cv[k+1]),
      .dn_ready(cr[k+1]),
      .dn_data (cd[k+1]),
      .dn_side (cs[k+1])
    );
  end

  // ---------------------------------------------------------------
  // stage r: apply the cosine sign, round cos and sin to Q1.14
  // ---------------------------------------------------------------
  logic                 r_v, rdy_r, rdy_m1;
  logic signed [SW-1:0] r_c, r_s;
  logic signed [15:0]   r_ax, r_ay, r_az;
  logic [W-1:0]         c_full, s_full;

  // negate by invert plus carry-in, sharing the add with the rounding
  assign c_full = (cd[NSTEP].x ^ {W{cs[NSTEP].flip}}) + W'(cs[NSTEP].flip) + W'(32768);
  assign s_full = cd[NSTEP].y + W'(32768);

  assign rdy_r = !r_v || rdy_m1;
  assign cr[NSTEP] = rdy_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (rdy_r) begin
      r_v <= cv[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_r && cv[NSTEP]) begin
      r_c <= $signed(c_full[W-1:16]);
      r_s <= $signed(s_full[W-1:16]);
      r_ax <= cs[NSTEP].axis_x;
      r_ay <= cs[NSTEP].axis_y;
      r_az <= cs[NSTEP].axis_z;
    end
  end

  // ---------------------------------------------------------------
  // stage m1: t = 1 - cos, axis outer products, axis times sine
  // ---------------------------------------------------------------
  logic                 m1_v, rdy_m2;
  logic signed [TW-1:0] m1_t;
  logic signed [SW-1:0] m1_c;
  logic signed [PW-1:0] m1_p [6];
  logic signed [NW-1:0] m1_ns [3];
  logic signed [PW-1:0] p_n [6];
  logic signed [NW-1:0] ns_n [3];

  // outer products in order xx yy zz xy xz yz
  assign p_n[0] = r_ax * r_ax;
  assign p_n[1] = r_ay * r_ay;
  assign p_n[2] = r_az * r_az;
  assign p_n[3] = r_ax * r_ay;
  assign p_n[4] = r_ax * r_az;
  assign p_n[5] = r_ay * r_az;
  assign ns_n[0] = r_ax * r_s;
  assign ns_n[1] = r_ay * r_s;
  assign ns_n[2] = r_az * r_s;

  assign rdy_m1 = !m1_v || rdy_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else if (rdy_m1) begin
      m1_v <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m1 && r_v) begin
      m1_t <= TW'(16384) - TW'(r_c);
      m1_c <= r_c;
      m1_p <= p_n;
      m1_ns <= ns_n;
    end
  end

  // ---------------------------------------------------------------
  // stage m2: scale outer products by t
  // ---------------------------------------------------------------
  logic                 m2_v, rdy_m3;
  logic signed [SW-1:0] m2_c;
  logic signed [QW-1:0] m2_q [6];
  logic signed [NW-1:0] m2_ns [3];
  logic signed [QW-1:0] q_n [6];

  for (genvar k = 0; k < 6; k++) begin : g_scale
    assign q_n[k] = m1_p[k] * m1_t;
  end

  assign rdy_m2 = !m2_v || rdy_m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else if (rdy_m2) begin
      m2_v <= m1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m2 && m1_v) begin
      m2_c <= m1_c;
      m2_q <= q_n;
      m2_ns <= m1_ns;
    end
  end

  // ---------------------------------------------------------------
  // stage m3: Q42 entry sums with the rounding half added in
  // ---------------------------------------------------------------
  logic                 m3_v, rdy_o;
  logic signed [EW-1:0] m3_e [9];
  logic signed [EW-1:0] e_n [9];
  logic signed [EW-1:0] cw, qe [6], se [3];

  assign cw = EW'(m2_c) <<< 28;
  for (genvar k = 0; k < 6; k++) begin : g_qe
    assign qe[k] = EW'(m2_q[k]);
  end
  for (genvar k = 0; k < 3; k++) begin : g_se
    assign se[k] = EW'(m2_ns[k]) <<< 14;
  end

  // row-major entries; skew terms from the cross-product matrix of the axis
  assign e_n[0] = cw + qe[0] + RND;
  assign e_n[1] = qe[3] - se[2] + RND;
  assign e_n[2] = qe[4] + se[1] + RND;
  assign e_n[3] = qe[3] + se[2] + RND;
  assign e_n[4] = cw + qe[1] + RND;
  assign e_n[5] = qe[5] - se[0] + RND;
  assign e_n[6] = qe[4] - se[1] + RND;
  assign e_n[7] = qe[5] + se[0] + RND;
  assign e_n[8] = cw + qe[2] + RND;

  assign rdy_m3 = !m3_v || rdy_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_v <= 1'b0;
    end else if (rdy_m3) begin
      m3_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_m3 && m2_v) begin
      m3_e <= e_n;
    end
  end

  // ---------------------------------------------------------------
  // output stage: drop to Q1.14 and saturate to -1..1
  // ---------------------------------------------------------------
  logic [15:0] o_n [9];

  for (genvar k = 0; k < 9; k++) begin : g_sat
    logic signed [VW-1:0] v;
    assign v = m3_e[k][EW-1:28];
    always_comb begin
      if (v > ONE_V) begin
        o_n[k] = ONE_V[15:0];
      end else if (v < NEG_ONE_V) begin
        o_n[k] = NEG_ONE_V[15:0];
      end else begin
        o_n[k] = v[15:0];
      end
    end
  end

  assign rdy_o = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_o) begin
      out_valid <= m3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_o && m3_v) begin
      r00 <= o_n[0];
      r01 <= o_n[1];
      r02 <= o_n[2];
      r10 <= o_n[3];
      r11 <= o_n[4];
      r12 <= o_n[5];
      r20 <= o_n[6];
      r21 <= o_n[7];
      r22 <= o_n[8];
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_in_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> a_v)
    else $error("accepted input did not reach the reduce stage");

  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    b_v |-> (RW'(b_data.z) <= aarm_pkg::Q30_HALF_PI) &&
            (RW'(b_data.z) >= aarm_pkg::Q30_NEG_HALF_PI))
    else $error("folded angle outside -pi/2..pi/2");

  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    m3_v && !rdy_o |=> m3_v && $stable(m3_e[0]) && $stable(m3_e[8]))
    else $error("entry sums changed while the output was stalled");

  a_out_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(r00) <= 16'sd16384) && ($signed(r00) >= -16'sd16384) &&
                  ($signed(r12) <= 16'sd16384) && ($signed(r12) >= -16'sd16384))
    else $error("matrix entry outside -1..1");

endmodule

`default_nettype wire

FILE: design/aarm_cordic_cell.sv
// one cordic rotation iteration with its own pipeline register and handshake
`default_nettype none

module aarm_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire aarm_pkg::cordic_t up_data,
  input  wire aarm_pkg::side_t   up_side,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output aarm_pkg::cordic_t     dn_data,
  output aarm_pkg::side_t       dn_side
);

  localparam int W = aarm_pkg::CW;
  localparam logic signed [W-1:0] ATAN = W'(aarm_pkg::atan_q30(STEP));

  logic signed [W-1:0] x, y, z;
  logic signed [W-1:0] x_sh, y_sh;
  aarm_pkg::cordic_t   data_next;
  logic                load;

  assign x = up_data.x;
  assign y = up_data.y;
  assign z = up_data.z;
  assign x_sh = x >>> STEP;
  assign y_sh = y >>> STEP;

  // rotate toward zero residual angle
  always_comb begin
    if (!z[W-1]) begin
      data_next.x = x - y_sh;
      data_next.y = y + x_sh;
      data_next.z = z - ATAN;
    end else begin
      data_next.x = x + y_sh;
      data_next.y = y - x_sh;
      data_next.z = z + ATAN;
    end
  end

  assign load = !dn_valid || dn_ready;
  assign up_ready = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (load) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      dn_data <= data_next;
      dn_side <= up_side;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_axis_angle_rotation_matrix.sv
// self-checking testbench for the axis-angle to rotation matrix pipeline
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix;

  // block configuration and the fixed-point constants of the rotation math
  localparam int     CORDIC_STEPS = 14;
  localparam int     STEPS_USED   = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam longint PI_Q30       = 64'sd3373259426;
  localparam longint TWO_PI_Q30   = 64'sd6746518852;
  localparam longint HALF_PI_Q30  = 64'sd1686629713;
  localparam longint GAIN_Q30     = 64'sd652032874;
  localparam longint ONE_Q14      = 64'sd16384;
  localparam int     N_RANDOM     = 1900;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     DRAIN_CYCLES = CORDIC_STEPS + 16;

  // truncated atan(2^-i) in Q30
  localparam longint ATAN_Q30 [32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
    64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
    64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000
  };

  // one rotation request: axis in Q1.14, angle in Q4.12
  typedef struct packed {
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic signed [15:0] theta;
  } rot_in_t;

  // nine Q1.14 entries, element 0 is r00, element 8 is r22
  typedef logic [8:0][15:0] rot_mat_t;

  // receiver stall patterns
  typedef enum logic [1:0] {
    RX_FREE,
    RX_BUSY,
    RX_SLOW,
    RX_TOGGLE
  } rx_mode_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [15:0] axis_x    = '0;
  logic [15:0] axis_y    = '0;
  logic [15:0] axis_z    = '0;
  logic [15:0] angle     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;

  rot_in_t  rot_backlog [$];   // requests not yet offered to the block
  rot_mat_t pending_mats [$];  // matrices owed by the block, oldest first

  string entry_name [9] = '{"r00", "r01", "r02", "r10", "r11", "r12", "r20", "r21", "r22"};

  int       n_directed  = 0;
  int       n_accepted  = 0;
  int       n_checked   = 0;
  int       errors      = 0;
  bit       in_took     = 1'b0;
  bit       hold_off    = 1'b0;
  int       burst_left  = 0;
  int       gap_left    = 0;
  rx_mode_t rx_mode     = RX_FREE;
  int       mode_left   = 0;

  axis_angle_rotation_matrix #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .axis_x   (axis_x),
    .axis_y   (axis_y),
    .axis_z   (axis_z),
    .angle    (angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .r00      (r00),
    .r01      (r01),
    .r02      (r02),
    .r10      (r10),
    .r11      (r11),
    .r12      (r12),
    .r20      (r20),
    .r21      (r21),
    .r22      (r22)
  );

  // rodrigues rotation matrix with a cordic sine/cosine, bit exact to the pipeline
  function automatic rot_mat_t rodrigues_matrix(rot_in_t r);
    longint   vx, vy, vz, z, x, y, x_next, c, s, t, cw, v;
    longint   acc [9];
    bit       flip;
    rot_mat_t m;
    vx = longint'(signed'(r.ux));
    vy = longint'(signed'(r.uy));
    vz = longint'(signed'(r.uz));
    z  = longint'(signed'(r.theta)) * 262144;
    x  = GAIN_Q30;
    y  = 0;
    flip = 1'b0;
    // wrap into -pi..pi, then fold into -pi/2..pi/2 with a cosine sign flip
    while (z > PI_Q30) z -= TWO_PI_Q30;
    while (z < -PI_Q30) z += TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z = PI_Q30 - z;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = -PI_Q30 - z;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS_USED; i++) begin
      if (z >= 0) begin
        x_next = x - (y >>> i);
        y      = y + (x >>> i);
        z      = z - ATAN_Q30[i];
      end else begin
        x_next = x + (y >>> i);
        y      = y - (x >>> i);
        z      = z + ATAN_Q30[i];
      end
      x = x_next;
    end
    if (flip) x = -x;
    c  = (x + 32768) >>> 16;
    s  = (y + 32768) >>> 16;
    t  = ONE_Q14 - c;
    cw = c * 268435456;
    // entries in Q42
    acc[0] = cw + vx * vx * t;
    acc[1] = vx * vy * t - vz * s * ONE_Q14;
    acc[2] = vx * vz * t + vy * s * ONE_Q14;
    acc[3] = vy * vx * t + vz * s * ONE_Q14;
    acc[4] = cw + vy * vy * t;
    acc[5] = vy * vz * t - vx * s * ONE_Q14;
    acc[6] = vz * vx * t - vy * s * ONE_Q14;
    acc[7] = vz * vy * t + vx * s * ONE_Q14;
    acc[8] = cw + vz * vz * t;
    for (int k = 0; k < 9; k++) begin
      v = (acc[k] + 134217728) >>> 28;
      if (v > ONE_Q14) v = ONE_Q14;
      else if (v < -ONE_Q14) v = -ONE_Q14;
      m[k] = v[15:0];
    end
    return m;
  endfunction

  function automatic rot_in_t make_rot(int ax, int ay, int az, int th);
    rot_in_t r;
    r.ux    = ax[15:0];
    r.uy    = ay[15:0];
    r.uz    = az[15:0];
    r.theta = th[15:0];
    return r;
  endfunction

  // random request: mostly unit axes with angles in -pi..pi, the rest looser or raw bits
  function automatic rot_in_t random_rot();
    real     fx, fy, fz, len;
    int      pick, th, sgn;
    rot_in_t r;
    pick = $urandom_range(0, 9);
    th   = ($urandom_range(0, 9) < 7) ? int'($urandom_range(0, 25736)) - 12868
                                      : int'($urandom_range(0, 65535));
    sgn  = $urandom_range(0, 1) ? 16384 : -16384;
    if (pick <= 5) begin
      fx  = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
      fy  = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
      fz  = real'($urandom_range(0, 2000)) / 1000.0 - 1.0;
      len = $sqrt(fx * fx + fy * fy + fz * fz);
      if (len < 0.05) begin
        r = make_rot(sgn, 0, 0, th);
      end else begin
        r = make_rot($rtoi(fx / len * 16384.0 + ((fx >= 0.0) ? 0.5 : -0.5)),
                     $rtoi(fy / len * 16384.0 + ((fy >= 0.0) ? 0.5 : -0.5)),
                     $rtoi(fz / len * 16384.0 + ((fz >= 0.0) ? 0.5 : -0.5)), th);
      end
    end else if (pick <= 7) begin
      r = make_rot(int'($urandom_range(0, 32768)) - 16384,
                   int'($urandom_range(0, 32768)) - 16384,
                   int'($urandom_range(0, 32768)) - 16384, th);
    end else if (pick == 8) begin
      r = make_rot($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535));
    end else begin
      // rotation about one coordinate axis
      case ($urandom_range(0, 2))
        0:       r = make_rot(sgn, 0, 0, th);
        1:       r = make_rot(0, sgn, 0, th);
        default: r = make_rot(0, 0, sgn, th);
      endcase
    end
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // driver: bursts of transfers separated by random gaps, inputs change on the falling edge
  always @(negedge clk) begin : drive_p
    rot_in_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // offer stays put until the block takes it
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (rot_backlog.size() > 0) begin
      nxt = rot_backlog.pop_front();
      axis_x   <= nxt.ux;
      axis_y   <= nxt.uy;
      axis_z   <= nxt.uz;
      angle    <= nxt.theta;
      in_valid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver: switches between stall patterns, forced off during the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_BUSY:   out_ready <= ($urandom_range(0, 9) < 7);
          RX_SLOW:   out_ready <= ($urandom_range(0, 3) == 0);
          RX_TOGGLE: out_ready <= ~out_ready;
          default:   out_ready <= 1'b1;
        endcase
      end
    end
  end

  // long receiver hold-off while the sender keeps offering, so the pipe fills and
  // in_ready must drop
  initial begin
    wait (n_accepted >= 400);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // monitor: predicts on every input transfer, checks every output transfer
  always @(posedge clk) begin : watch_p
    rot_mat_t got, want;
    in_took = !rst && in_valid && in_ready;
    if (in_took) begin
      pending_mats.push_back(rodrigues_matrix({axis_x, axis_y, axis_z, angle}));
      n_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      got = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
      if (pending_mats.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: matrix transfer with nothing outstanding, r00=%0d",
                   $realtime, $signed(r00));
      end else begin
        want = pending_mats.pop_front();
        n_checked++;
        for (int k = 0; k < 9; k++) begin
          if (got[k] !== want[k]) begin
            errors++;
            if (errors <= 10)
              $display("%0t: matrix %0d %s expected %0d got %0d", $realtime, n_checked,
                       entry_name[k], $signed(want[k]), $signed(got[k]));
          end
        end
      end
    end
  end

  // main sequence: stimulus, reset, drain, verdict
  initial begin
    // directed: axis-aligned, diagonal, saturating, out of range and zero axes,
    // angles at zero, at the pi/2 fold, at the pi wrap, at 2pi and at both field extremes
    rot_backlog.push_back(make_rot( 16384,      0,      0,      0));
    rot_backlog.push_back(make_rot(     0,  16384,      0,   6434));
    rot_backlog.push_back(make_rot(     0,      0,  16384,  -6434));
    rot_backlog.push_back(make_rot( 16384,      0,      0,   6433));
    rot_backlog.push_back(make_rot(     0,  16384,      0,  -6433));
    rot_backlog.push_back(make_rot(     0,      0,  16384,  12867));
    rot_backlog.push_back(make_rot( 16384,      0,      0,  12868));
    rot_backlog.push_back(make_rot(     0, -16384,      0, -12867));
    rot_backlog.push_back(make_rot(     0,      0, -16384, -12868));
    rot_backlog.push_back(make_rot(  9459,   9459,   9459,  32767));
    rot_backlog.push_back(make_rot( -9459,   9459,  -9459, -32768));
    rot_backlog.push_back(make_rot( 16384,  16384,  16384,  12868));
    rot_backlog.push_back(make_rot(-16384, -16384, -16384,  -3217));
    rot_backlog.push_back(make_rot( 32767, -32768,      0,   4096));
    rot_backlog.push_back(make_rot(-32768,  32767, -32768,  -4096));
    rot_backlog.push_back(make_rot(     0,      0,      0,   3000));
    rot_backlog.push_back(make_rot( 11585,  11585,      0,  25736));
    rot_backlog.push_back(make_rot(     0, -11585,  11585, -25736));
    rot_backlog.push_back(make_rot(    -1,      1,     -1,      1));
    rot_backlog.push_back(make_rot( 16384, -16384,  16384,     -1));
    rot_backlog.push_back(make_rot(-16384,      0,      0,   8192));
    rot_backlog.push_back(make_rot(     0,      0,  16384, -20000));
    rot_backlog.push_back(make_rot(-32768, -32768, -32768,  32767));
    rot_backlog.push_back(make_rot( 32767,  32767,  32767, -32768));
    n_directed = rot_backlog.size();
    for (int n = 0; n < N_RANDOM; n++) rot_backlog.push_back(random_rot());

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (n_accepted == n_directed + N_RANDOM);
    while (pending_mats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d directed and %0d random axis-angle transfers, %0d matrices compared",
             n_directed, N_RANDOM, n_checked);
    $display("output held off for %0d cycles once; %0d mismatched or stray entries",
             HOLD_CYCLES, errors);
    if (errors == 0 && pending_mats.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("timeout with %0d of %0d transfers accepted, %0d matrices outstanding",
             n_accepted, n_directed + N_RANDOM, pending_mats.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: sim.f
design/aarm_pkg.sv
design/aarm_cordic_cell.sv
design/axis_angle_rotation_matrix.sv
tb/sv/tb_axis_angle_rotation_matrix.sv
